// ----- sv/periodic_alarm_phase_timer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic alarm phase timer
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_ALARM_PHASE_TIMER_ASSERT_SVH
`define PERIODIC_ALARM_PHASE_TIMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PAPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PAPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/papt_pkg.sv -----
// ----------------------------------------------------------------------------
// papt_pkg
// Codes, reset values and constants of the periodic alarm phase timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package papt_pkg;

    localparam int TIME_W = 32;
    localparam int LEN_W  = 16;
    localparam int SEC_W  = 7;

    // opcodes carried in s_tuser
    localparam logic [1:0] OP_PROCESS = 2'd0;
    localparam logic [1:0] OP_TOGGLE  = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WAIT     = 2'd0;
    localparam logic [1:0] REG_ALERT    = 2'd1;
    localparam logic [1:0] REG_BUZZ_ON  = 2'd2;
    localparam logic [1:0] REG_BUZZ_OFF = 2'd3;

    localparam logic [LEN_W-1:0] WAIT_RST     = 16'd2000;
    localparam logic [LEN_W-1:0] ALERT_RST    = 16'd10000;
    localparam logic [LEN_W-1:0] BUZZ_ON_RST  = 16'd200;
    localparam logic [LEN_W-1:0] BUZZ_OFF_RST = 16'd300;

    localparam logic [SEC_W-1:0] SHOWN_NONE = 7'd127;

    // ceil(x/1000) = floor((x+999) * 67109 / 2^26), exact for x+999 < 2^17
    localparam logic [16:0] SEC_ROUND = 17'd999;
    localparam logic [16:0] SEC_RECIP = 17'd67109;
    localparam int          SEC_SHIFT = 26;

endpackage

// ----- sv/periodic_alarm_phase_timer.sv -----
// ----------------------------------------------------------------------------
// periodic_alarm_phase_timer: wait/alert phase timer with pulsed buzzer
// Registered in the input register, then the result register; one item per cycle
// while the result stream is not stalled by m_tready.
// rst_n (async, low) restores register defaults, stopped, nothing shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_alarm_phase_timer
    import papt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] now_ms
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] led_on, [1] buzzer_on, [17:2] ms_remaining,
                                   // [24:18] seconds_remaining, [25] redraw, [31:26] zero
);

    `include "periodic_alarm_phase_timer_assert.svh"

    // configuration
    logic [LEN_W-1:0] wait_reg, alert_reg, buzz_on_reg, buzz_off_reg;

    // input register
    logic              in_valid_reg;
    logic [1:0]        in_op_reg;
    logic [TIME_W-1:0] in_now_reg;

    // timer state
    logic              running_reg, running_next;
    logic              alert_reg_q, alert_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              pulse_reg, pulse_next;
    logic [TIME_W-1:0] pulse_time_reg, pulse_time_next;
    logic [SEC_W-1:0]  shown_reg, shown_next;

    // result register
    logic              out_valid_reg;
    logic              led_reg, led_next;
    logic              buzz_reg, buzz_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [SEC_W-1:0]  secs_reg, secs_next;
    logic              redraw_reg, redraw_next;

    logic              advance;
    logic              step;
    logic [TIME_W-1:0] elapsed;
    logic [16:0]       round_sum;
    logic [33:0]       sec_prod;
    logic              is_cmd;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step      = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg     <= WAIT_RST;
            alert_reg    <= ALERT_RST;
            buzz_on_reg  <= BUZZ_ON_RST;
            buzz_off_reg <= BUZZ_OFF_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WAIT:     wait_reg     <= cfg_data;
                REG_ALERT:    alert_reg    <= cfg_data;
                REG_BUZZ_ON:  buzz_on_reg  <= cfg_data;
                REG_BUZZ_OFF: buzz_off_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg  <= s_tuser;
            in_now_reg <= s_tdata;
        end
    end

    assign is_cmd  = (in_op_reg == OP_TOGGLE) || (in_op_reg == OP_STOP);
    assign elapsed = in_now_reg - start_reg;

    always_comb
    begin
        logic              changed;
        logic [LEN_W-1:0]  remain;
        logic [LEN_W-1:0]  phase_len;
        changed         = 1'b0;
        remain          = wait_reg;
        phase_len       = alert_reg_q ? alert_reg : wait_reg;
        running_next    = running_reg;
        alert_next      = alert_reg_q;
        start_next      = start_reg;
        pulse_next      = pulse_reg;
        pulse_time_next = pulse_time_reg;

        if (is_cmd)
        begin
            running_next    = (in_op_reg == OP_TOGGLE) ? !running_reg : 1'b0;
            alert_next      = 1'b0;
            start_next      = in_now_reg;
            pulse_next      = 1'b0;
            pulse_time_next = in_now_reg;
        end
        else if (running_reg)
        begin
            // buzzer events only run in the alert phase; compare is absolute, no wrap
            if (alert_reg_q && (in_now_reg >= pulse_time_reg))
            begin
                pulse_next      = !pulse_reg;
                pulse_time_next = in_now_reg +
                    {{(TIME_W-LEN_W){1'b0}}, pulse_reg ? buzz_off_reg : buzz_on_reg};
            end
            if (elapsed >= {{(TIME_W-LEN_W){1'b0}}, phase_len})
            begin
                alert_next      = !alert_reg_q;
                start_next      = in_now_reg;
                pulse_next      = 1'b0;
                pulse_time_next = in_now_reg;
                changed         = 1'b1;
                remain          = '0;
            end
            else
            begin
                remain = phase_len - elapsed[LEN_W-1:0];
            end
        end

        round_sum   = {1'b0, remain} + SEC_ROUND;
        sec_prod    = round_sum * SEC_RECIP;
        secs_next   = sec_prod[SEC_SHIFT+SEC_W-1:SEC_SHIFT];
        remain_next = remain;
        led_next    = running_next && alert_next && !is_cmd;
        buzz_next   = led_next && pulse_next;

        if (is_cmd)
        begin
            redraw_next = 1'b1;
            shown_next  = SHOWN_NONE;
        end
        else
        begin
            redraw_next = changed || (secs_next != shown_reg);
            shown_next  = redraw_next ? secs_next : shown_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            alert_reg_q    <= 1'b0;
            start_reg      <= '0;
            pulse_reg      <= 1'b0;
            pulse_time_reg <= '0;
            shown_reg      <= SHOWN_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                running_reg    <= running_next;
                alert_reg_q    <= alert_next;
                start_reg      <= start_next;
                pulse_reg      <= pulse_next;
                pulse_time_reg <= pulse_time_next;
                shown_reg      <= shown_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            led_reg    <= led_next;
            buzz_reg   <= buzz_next;
            remain_reg <= remain_next;
            secs_reg   <= secs_next;
            redraw_reg <= redraw_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, redraw_reg, secs_reg, remain_reg, buzz_reg, led_reg};

    `PAPT_ASSERT_SAME(a_led_needs_run, out_valid_reg && led_reg, running_reg,
        "led lit while timer stopped")
    `PAPT_ASSERT_SAME(a_buzz_needs_led, out_valid_reg && buzz_reg, led_reg,
        "buzzer on outside alert phase")
    `PAPT_ASSERT_SAME(a_secs_zero, out_valid_reg,
        (remain_reg == '0) == (secs_reg == '0),
        "seconds and milliseconds disagree on zero")
    `PAPT_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg,
        "input register dropped a stalled transaction")

endmodule

// ----- bench/periodic_alarm_phase_timer_tb.sv -----
// ----------------------------------------------------------------------------
// periodic_alarm_phase_timer_tb: self-checking bench for the alarm phase timer
// Drives time and command transactions and tracks the timer state in a local
// model. Each result is checked field by field against the queued prediction.
// Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_alarm_phase_timer_tb;
    import papt_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, decoded as a process step
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic             redraw;
        logic [SEC_W-1:0] secs;
        logic [LEN_W-1:0] ms_left;
        logic             buzzer;
        logic             led;
    } alarm_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WAIT;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] now_ms
    logic [1:0]  s_tuser = OP_PROCESS; // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [0] led, [1] buzzer, [17:2] ms left, [24:18] secs,
                                    // [25] redraw, [31:26] zero

    periodic_alarm_phase_timer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // timer model
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0]  cfg_wait, cfg_alert, cfg_buzz_on, cfg_buzz_off;
    logic              run_on, alert_phase, buzz_pulse;
    logic [TIME_W-1:0] phase_t0, pulse_due;
    logic [SEC_W-1:0]  shown_sec;

    alarm_out_t expected_outputs[$];
    int fault_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    task automatic reset_model();
        cfg_wait     = WAIT_RST;
        cfg_alert    = ALERT_RST;
        cfg_buzz_on  = BUZZ_ON_RST;
        cfg_buzz_off = BUZZ_OFF_RST;
        run_on       = 1'b0;
        alert_phase  = 1'b0;
        buzz_pulse   = 1'b0;
        phase_t0     = '0;
        pulse_due    = '0;
        shown_sec    = SHOWN_NONE;
    endtask

    function automatic logic [SEC_W-1:0] ceil_seconds(input logic [31:0] ms);
        logic [31:0] s;
        s = (ms + 32'd999) / 32'd1000;
        return s[SEC_W-1:0];
    endfunction

    function automatic alarm_out_t predict_alarm_outputs(input logic [1:0] op,
                                                         input logic [31:0] now);
        alarm_out_t  r;
        logic [31:0] elapsed;
        logic [31:0] remain;
        logic [SEC_W-1:0] secs;
        logic        changed;
        changed = 1'b0;
        if (op == OP_TOGGLE || op == OP_STOP)
        begin
            run_on      = (op == OP_TOGGLE) ? !run_on : 1'b0;
            alert_phase = 1'b0;
            phase_t0    = now;
            buzz_pulse  = 1'b0;
            pulse_due   = now;
            shown_sec   = SHOWN_NONE;
            r.led     = 1'b0;
            r.buzzer  = 1'b0;
            r.ms_left = cfg_wait;
            r.secs    = ceil_seconds({16'd0, cfg_wait});
            r.redraw  = 1'b1;
            return r;
        end
        remain = {16'd0, cfg_wait};
        if (run_on)
        begin
            if (!alert_phase)
            begin
                elapsed = now - phase_t0;
                if (elapsed >= {16'd0, cfg_wait})
                begin
                    alert_phase = 1'b1;
                    phase_t0    = now;
                    buzz_pulse  = 1'b0;
                    pulse_due   = now;
                    changed     = 1'b1;
                end
                remain = (elapsed < {16'd0, cfg_wait}) ? {16'd0, cfg_wait} - elapsed : '0;
            end
            else
            begin
                // absolute compare, wrap of the pulse time is not handled
                if (now >= pulse_due)
                begin
                    buzz_pulse = !buzz_pulse;
                    pulse_due  = now + (buzz_pulse ? {16'd0, cfg_buzz_on}
                                                   : {16'd0, cfg_buzz_off});
                end
                elapsed = now - phase_t0;
                if (elapsed >= {16'd0, cfg_alert})
                begin
                    alert_phase = 1'b0;
                    phase_t0    = now;
                    buzz_pulse  = 1'b0;
                    pulse_due   = now;
                    changed     = 1'b1;
                end
                remain = (elapsed < {16'd0, cfg_alert}) ? {16'd0, cfg_alert} - elapsed : '0;
            end
        end
        secs      = ceil_seconds(remain);
        r.led     = run_on && alert_phase;
        r.buzzer  = run_on && alert_phase && buzz_pulse;
        r.ms_left = remain[LEN_W-1:0];
        r.secs    = secs;
        r.redraw  = changed || (secs != shown_sec);
        if (r.redraw)
            shown_sec = secs;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checker and watchdog
    // ------------------------------------------------------------------------
    alarm_out_t want;
    alarm_out_t got;
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[25:0];
            if (expected_outputs.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: %h", m_tdata);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (got.led !== want.led || got.buzzer !== want.buzzer ||
                    got.ms_left !== want.ms_left || got.secs !== want.secs ||
                    got.redraw !== want.redraw || m_tdata[31:26] !== 6'd0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: exp led=%0d buz=%0d ms=%0d sec=%0d redraw=%0d",
                                 want.led, want.buzzer, want.ms_left, want.secs,
                                 want.redraw);
                        $display("          got led=%0d buz=%0d ms=%0d sec=%0d redraw=%0d pad=%h",
                                 got.led, got.buzzer, got.ms_left, got.secs, got.redraw,
                                 m_tdata[31:26]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [31:0] now);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= now;
        do
            @(posedge clk);
        while (!s_tready);
        expected_outputs.push_back(predict_alarm_outputs(op, now));
        items_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WAIT:     cfg_wait     = value;
            REG_ALERT:    cfg_alert    = value;
            REG_BUZZ_ON:  cfg_buzz_on  = value;
            REG_BUZZ_OFF: cfg_buzz_off = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] w, input logic [15:0] a,
                              input logic [15:0] on, input logic [15:0] off);
        write_reg(REG_WAIT, w);
        write_reg(REG_ALERT, a);
        write_reg(REG_BUZZ_ON, on);
        write_reg(REG_BUZZ_OFF, off);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset timing: stopped output, commands, one full wait/alert cycle
    task automatic test_default_cycle();
        send_item(OP_PROCESS, 32'd0);
        send_item(OP_PROCESS, 32'hFFFF_FFFF);
        send_item(OP_SPARE, 32'd12345);
        send_item(OP_STOP, 32'd5);
        send_item(OP_TOGGLE, 32'd1000);
        send_item(OP_PROCESS, 32'd1001);
        send_item(OP_PROCESS, 32'd2000);
        send_item(OP_PROCESS, 32'd3000);   // wait ends
        send_item(OP_PROCESS, 32'd3000);   // first pulse on
        send_item(OP_PROCESS, 32'd3200);
        send_item(OP_PROCESS, 32'd3500);
        send_item(OP_PROCESS, 32'd13000);  // alert ends
        send_item(OP_TOGGLE, 32'd13000);
    endtask

    task automatic test_register_extremes();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_PROCESS, 32'd0);
        send_item(OP_TOGGLE, 32'd0);
        send_item(OP_PROCESS, 32'd65534);
        send_item(OP_PROCESS, 32'd65535);
        send_item(OP_PROCESS, 32'd65600);
        send_item(OP_PROCESS, 32'd131070);
        set_timing(16'd1, 16'd1, 16'd1, 16'd1);
        send_item(OP_TOGGLE, 32'hFFFF_FFFF);
        send_item(OP_PROCESS, 32'd0);
        send_item(OP_PROCESS, 32'd0);
        send_item(OP_PROCESS, 32'd1);
    endtask

    // pulse time wraps to a small value and flips the buzzer right away
    task automatic test_time_wrap();
        set_timing(16'd1, 16'd1000, 16'd100, 16'hFFFF);
        send_item(OP_STOP, 32'hFFFF_FFEE);
        send_item(OP_TOGGLE, 32'hFFFF_FFEE);
        send_item(OP_PROCESS, 32'hFFFF_FFF0);
        send_item(OP_PROCESS, 32'hFFFF_FFF0);
        send_item(OP_PROCESS, 32'hFFFF_FFF5);
        send_item(OP_PROCESS, 32'h0000_0010);
        send_item(OP_PROCESS, 32'h0000_03E0);
    endtask

    task automatic run_session(input int steps, input bit wide_timing);
        logic [31:0] t;
        int step_max;
        int r;
        if (wide_timing)
        begin
            set_timing(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
            step_max = 20000;
        end
        else
        begin
            set_timing(16'($urandom_range(1, 60)), 16'($urandom_range(1, 150)),
                       16'($urandom_range(1, 25)), 16'($urandom_range(1, 25)));
            step_max = 12;
        end
        t = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
        send_item(OP_STOP, t);
        send_item(OP_TOGGLE, t);
        for (int i = 0; i < steps; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                send_item(OP_TOGGLE, t);
            end
            else if (r < 5)
            begin
                send_item(OP_STOP, t);
            end
            else if (r < 7)
            begin
                t = t - $urandom_range(20);   // time going backwards
                send_item(OP_PROCESS, t);
            end
            else if (r < 9)
            begin
                t = $urandom;
                send_item(OP_PROCESS, t);
            end
            else
            begin
                t = t + $urandom_range(step_max);
                send_item((r < 12) ? OP_SPARE : OP_PROCESS, t);
            end
        end
    endtask

    task automatic test_random_sessions(input int send_pct, input int stall_pct,
                                        input int count);
        int start;
        start = items_sent;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (items_sent - start < count)
            run_session($urandom_range(20, 60), $urandom_range(9) == 0);
        drain_results();
    endtask

    task automatic test_command_noise(input int count);
        set_timing(WAIT_RST, ALERT_RST, BUZZ_ON_RST, BUZZ_OFF_RST);
        for (int i = 0; i < count; i++)
            send_item(2'($urandom_range(3)), $urandom);
    endtask

    initial
    begin
        reset_model();
        @(posedge rst_n);
        test_default_cycle();
        test_register_extremes();
        test_time_wrap();
        test_random_sessions(0, 0, 120);
        test_random_sessions(87, 0, 120);
        test_random_sessions(0, 87, 120);
        test_random_sessions(12, 12, 120);
        test_command_noise(40);
        drain_results();
        if (fault_count == 0 && expected_outputs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
